// ----- hw/rtl/mwr_pkg.sv -----
// shared types and constants of the windowed rate meter
`default_nettype none

package mwr_pkg;

  localparam int CH_W    = 4;
  localparam int ELAP_W  = 32;
  localparam int COUNT_W = 24;
  localparam int RATE_W  = 48;
  localparam int FRAC_W  = 32;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // one ring slot: last count and elapsed time of a channel
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [ELAP_W-1:0]  elapsed;
  } mwr_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mwr_div_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/multichannel_windowed_rate.sv -----
// top level of the per-channel windowed throughput meter
//
//  channel  dir  word fields (lsb first)
//  in_*     in   tdata: channel[3:0], elapsed_time[35:4], item_count[59:36]
//  out_*    out  tdata: rate[47:0]; tuser: bad_channel[0], zero_time[1]
//
// a valid channel: accept, slot read, update, one divide step per numerator
// bit, quotient pickup and result load; a bad channel goes from accept
// straight to result load, a zero window time from update. in_tready is high only between items.
// a finished result waits in the output register while the next word is
// taken; a stalled output only holds back the following result load.
// synchronous reset clears totals, slot pointers and the slot valid bits.
`default_nettype none

module multichannel_windowed_rate
  import mwr_pkg::*;
#(
  parameter int WINDOW   = 5,
  parameter int CHANNELS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // channel, elapsed_time, item_count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // rate
  output logic [1:0]       out_tuser   // bad_channel, zero_time
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CHI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TTOT_W = ELAP_W + SLOT_W;
  localparam int CTOT_W = COUNT_W + SLOT_W;
  localparam int NUM_W  = CTOT_W + FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_UPD,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state_r;
  logic [CH_W-1:0]     ch_r;
  logic [ELAP_W-1:0]   elap_r;
  logic [COUNT_W-1:0]  count_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [RATE_W-1:0]   res_rate_r;
  logic                res_bad_r;
  logic                res_zero_r;
  logic                out_valid_r;
  logic [RATE_W-1:0]   out_rate_r;
  logic                out_bad_r;
  logic                out_zero_r;

  logic [TTOT_W-1:0]   ttot_r [CHANNELS];
  logic [CTOT_W-1:0]   ctot_r [CHANNELS];
  logic [SLOT_W-1:0]   slot_r [CHANNELS];

  logic [CH_W-1:0]     in_ch;
  logic [ELAP_W-1:0]   in_elap;
  logic [COUNT_W-1:0]  in_count;
  logic                in_acc;
  logic [CHI_W-1:0]    chi;
  logic [SLOT_W-1:0]   slot_cur;
  logic [ADDR_W-1:0]   addr_nxt;
  mwr_entry_t          old_entry;
  mwr_entry_t          new_entry;
  logic [TTOT_W-1:0]   ttot_nxt;
  logic [CTOT_W-1:0]   ctot_nxt;
  logic                div_start;
  mwr_div_sts_t        div_sts;
  logic [RATE_W-1:0]   div_rate;
  logic                out_free;

  assign in_ch    = in_tdata[3:0];
  assign in_elap  = in_tdata[35:4];
  assign in_count = in_tdata[59:36];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign chi      = ch_r[CHI_W-1:0];
  assign slot_cur = slot_r[chi];
  assign addr_nxt = ADDR_W'(32'(chi) * 32'(WINDOW) + 32'(slot_cur));

  assign new_entry.count   = count_r;
  assign new_entry.elapsed = elap_r;

  // totals updated by difference against the slot being replaced
  assign ttot_nxt = ttot_r[chi] - TTOT_W'(old_entry.elapsed) + TTOT_W'(elap_r);
  assign ctot_nxt = ctot_r[chi] - CTOT_W'(old_entry.count) + CTOT_W'(count_r);

  assign div_start = (state_r == S_UPD) && (ttot_nxt != '0);

  // slot read is issued straight from the computed address, the write in the cycle after
  mwr_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (state_r == S_UPD),
    .wr_addr(addr_r),
    .wr_data(new_entry),
    .rd_en  (state_r == S_RD),
    .rd_addr(addr_nxt),
    .rd_data(old_entry)
  );

  mwr_div #(
    .NUM_W(NUM_W),
    .DEN_W(TTOT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  ({ctot_nxt, {FRAC_W{1'b0}}}),
    .den  (ttot_nxt),
    .sts  (div_sts),
    .rate (div_rate)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ttot_r[i] <= '0;
        ctot_r[i] <= '0;
        slot_r[i] <= '0;
      end
    end else if (state_r == S_UPD) begin
      ttot_r[chi] <= ttot_nxt;
      ctot_r[chi] <= ctot_nxt;
      slot_r[chi] <= (32'(slot_cur) + 1 >= WINDOW) ? '0 : slot_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ch_r    <= in_ch;
            elap_r  <= in_elap;
            count_r <= in_count;
            if (32'(in_ch) >= CHANNELS) begin
              res_rate_r <= '0;
              res_bad_r  <= 1'b1;
              res_zero_r <= 1'b0;
              state_r    <= S_OUT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          addr_r  <= addr_nxt;
          state_r <= S_UPD;
        end
        S_UPD: begin
          res_bad_r <= 1'b0;
          if (ttot_nxt == '0) begin
            res_rate_r <= RATE_MAX;
            res_zero_r <= 1'b1;
            state_r    <= S_OUT;
          end else begin
            res_zero_r <= 1'b0;
            state_r    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            res_rate_r <= div_rate;
            state_r    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rate_r  <= res_rate_r;
            out_bad_r   <= res_bad_r;
            out_zero_r  <= res_zero_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rate_r;
  assign out_tuser  = {out_zero_r, out_bad_r};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("bad channel and zero time both flagged");

  a_bad_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("bad channel word with nonzero rate");

  a_zero_time_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == RATE_MAX))
    else $error("zero time word not saturated");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ----- hw/rtl/mwr_ring.sv -----
// ring slot storage for all channels, valid bit per entry, registered read
`default_nettype none

module mwr_ring
  import mwr_pkg::*;
#(
  parameter int DEPTH = 50
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire mwr_entry_t               wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output mwr_entry_t                    rd_data
);

  mwr_entry_t             mem [DEPTH];
  logic       [DEPTH-1:0] valid_r;
  mwr_entry_t             rd_data_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // a slot never written since reset reads as zero
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/mwr_div.sv -----
// restoring bit-serial divider, one quotient bit per cycle, saturating result
`default_nettype none

module mwr_div
  import mwr_pkg::*;
#(
  parameter int NUM_W = 59,
  parameter int DEN_W = 35
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output mwr_div_sts_t           sts,
  output logic [RATE_W-1:0]      rate
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign diff    = rem_sh - {1'b0, den_r};
  assign ge      = !diff[DEN_W];
  assign rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r  <= {num_r[NUM_W-2:0], 1'b0};
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[NUM_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

  // quotient bits above the output width mean saturation
  assign rate = (|quot_r[NUM_W-1:RATE_W]) ? RATE_MAX : quot_r[RATE_W-1:0];

endmodule

`default_nettype wire

// ----- verif/multichannel_windowed_rate_tb.sv -----
// testbench for the per-channel windowed rate meter: stream driver, monitor, predictor
`timescale 1ns / 100ps

module multichannel_windowed_rate_tb;
  import mwr_pkg::*;

  localparam int WINDOW      = 5;
  localparam int CHANNELS    = 10;
  localparam int RANDOM_WORDS = 1700;
  localparam int CALM_TAIL   = 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              bad_channel;
    logic              zero_time;
  } meter_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [63:0]   pending_words[$];
  meter_result_t expected_rates[$];

  // predictor state, one window per channel
  logic [ELAP_W-1:0]  elapsed_hist[CHANNELS][WINDOW];
  logic [COUNT_W-1:0] count_hist[CHANNELS][WINDOW];
  logic [34:0]        elapsed_sum[CHANNELS];
  logic [26:0]        count_sum[CHANNELS];
  int                 next_slot[CHANNELS];

  int unsigned words_sent;
  int unsigned rates_seen;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  logic        hold_done;

  multichannel_windowed_rate #(
    .WINDOW  (WINDOW),
    .CHANNELS(CHANNELS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic meter_result_t meter_step(logic [63:0] word);
    logic [CH_W-1:0]    ch;
    logic [ELAP_W-1:0]  el;
    logic [COUNT_W-1:0] cnt;
    logic [63:0]        quotient;
    meter_result_t      r;
    int                 s;
    ch  = word[3:0];
    el  = word[35:4];
    cnt = word[59:36];
    r   = '0;
    if (ch >= CHANNELS) begin
      r.bad_channel = 1'b1;
      return r;
    end
    s = next_slot[ch];
    elapsed_sum[ch] = elapsed_sum[ch] - {3'b0, elapsed_hist[ch][s]} + {3'b0, el};
    count_sum[ch]   = count_sum[ch] - {3'b0, count_hist[ch][s]} + {3'b0, cnt};
    elapsed_hist[ch][s] = el;
    count_hist[ch][s]   = cnt;
    next_slot[ch] = (s == WINDOW - 1) ? 0 : s + 1;
    if (elapsed_sum[ch] == 0) begin
      r.rate      = RATE_MAX;
      r.zero_time = 1'b1;
    end else begin
      quotient = {5'b0, count_sum[ch], 32'b0} / {29'b0, elapsed_sum[ch]};
      r.rate = (quotient > {16'b0, RATE_MAX}) ? RATE_MAX : quotient[RATE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ELAP_W-1:0] pick_elapsed();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(1, 4096);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 24'($urandom_range(1, 1000));
      2:       return 24'hFF_FFFF - 24'($urandom_range(0, 255));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic queue_sample(logic [CH_W-1:0] ch, logic [ELAP_W-1:0] el,
                              logic [COUNT_W-1:0] cnt);
    pending_words.push_back({4'b0, cnt, el, ch});
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at word %0d: %s got %h want %h", rates_seen, what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rates.push_back(meter_step(in_tdata));
        words_sent <= words_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > CALM_TAIL && hold_left == 0 &&
                     (words_sent / 150) % 4 != 3 && $urandom_range(0, 7) == 0) begin
          send_gap  <= $urandom_range(0, 18);
          in_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_words.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    meter_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_rates.size() == 0) begin
          report_mismatch("unexpected word", {14'b0, out_tdata, out_tuser}, '0);
        end else begin
          want = expected_rates.pop_front();
          if (out_tdata !== want.rate)
            report_mismatch("rate", 64'(out_tdata), 64'(want.rate));
          if (out_tuser[0] !== want.bad_channel)
            report_mismatch("bad_channel", 64'(out_tuser[0]), 64'(want.bad_channel));
          if (out_tuser[1] !== want.zero_time)
            report_mismatch("zero_time", 64'(out_tuser[1]), 64'(want.zero_time));
        end
        rates_seen <= rates_seen + 1;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (pending_words.size() > CALM_TAIL && (rates_seen / 150) % 4 != 1 &&
                   $urandom_range(0, 7) == 0) begin
        recv_gap   <= $urandom_range(0, 18);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && words_sent == HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int               n;
    logic [CH_W-1:0]  ch;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    words_sent  = 0;
    rates_seen  = 0;
    mismatches  = 0;
    cycle_count = 0;
    send_gap    = 0;
    recv_gap    = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      elapsed_sum[c] = '0;
      count_sum[c]   = '0;
      next_slot[c]   = 0;
      for (int s = 0; s < WINDOW; s++) begin
        elapsed_hist[c][s] = '0;
        count_hist[c][s]   = '0;
      end
    end

    // empty window, then extremes on the same channel
    queue_sample(4'd0, 32'd0, 24'd0);
    queue_sample(4'd0, 32'hFFFF_FFFF, 24'hFF_FFFF);
    // quotient overflow saturates
    queue_sample(4'd1, 32'd1, 24'hFF_FFFF);
    queue_sample(4'd2, 32'd1, 24'd1);
    queue_sample(4'd2, 32'd0, 24'd5);
    // zero time with items counted
    queue_sample(4'd3, 32'd0, 24'd7);
    // out of range channels
    queue_sample(4'd10, 32'h1234_5678, 24'hAB_CDEF);
    queue_sample(4'd15, 32'hFFFF_FFFF, 24'hFF_FFFF);
    // full window of maxima plus a wrap on the top channel
    repeat (WINDOW + 1) queue_sample(CH_W'(CHANNELS - 1), 32'hFFFF_FFFF, 24'hFF_FFFF);
    // window time drains back to zero once the only nonzero slot is evicted
    queue_sample(4'd5, 32'd3, 24'd1);
    repeat (WINDOW) queue_sample(4'd5, 32'd0, 24'd2);
    queue_sample(4'd6, 32'h0000_FFFF, 24'd1000);

    n = 0;
    while (n < RANDOM_WORDS) begin
      if ($urandom_range(0, 39) == 0) begin
        // zero-time run to empty a channel's window time
        ch = CH_W'($urandom_range(0, CHANNELS - 1));
        repeat (WINDOW) queue_sample(ch, 32'd0, pick_count());
        n += WINDOW;
      end else begin
        ch = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(0, 15))
                                          : CH_W'($urandom_range(0, CHANNELS - 1));
        queue_sample(ch, pick_elapsed(), pick_count());
        n++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_tvalid || expected_rates.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- multichannel_windowed_rate.f -----
hw/rtl/mwr_pkg.sv
hw/rtl/mwr_ring.sv
hw/rtl/mwr_div.sv
hw/rtl/multichannel_windowed_rate.sv
verif/multichannel_windowed_rate_tb.sv
